// ===== hw/rtl/dppf_pkg.sv =====
`default_nettype none

package dppf_pkg;

  // Request codes carried in the low bits of in_tdata
  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_WAKE      = 3'd1,
    REQ_DIM       = 3'd2,
    REQ_OFF       = 3'd3,
    REQ_SLEEP_EN  = 3'd4,
    REQ_SLEEP_DIS = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_DIMMED = 2'd1,
    MODE_OFF    = 2'd2,
    MODE_SLEEP  = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMMED_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT  = 3'd4;

  localparam logic [7:0]  ACTIVE_LEVEL_RST = 8'd255;
  localparam logic [7:0]  DIMMED_LEVEL_RST = 8'd50;
  localparam logic [7:0]  OFF_LEVEL_RST    = 8'd0;
  localparam logic [23:0] DIM_TIMEOUT_RST  = 24'd45000;
  localparam logic [23:0] OFF_TIMEOUT_RST  = 24'd300000;

  localparam int IDLE_W   = 25;
  localparam int FSTEP_W  = 4;
  localparam int SPULSE_W = 11;

  localparam logic [FSTEP_W-1:0] FADE_FAST_MS      = 4'd5;
  localparam logic [FSTEP_W-1:0] FADE_SLOW_MS      = 4'd10;
  localparam logic [IDLE_W-1:0]  MANUAL_DIM_EXTRA  = 25'd1000;

  localparam int FADE_STEP_DEF    = 5;
  localparam int SLEEP_GAP_MS_DEF = 1000;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  active_level;
    logic [7:0]  dimmed_level;
    logic [7:0]  off_level;
    logic [23:0] dim_timeout_ms;
    logic [23:0] off_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic       sleep_pulse;
    logic       fading;
    mode_t      mode;
    logic       brightness_written;
    logic [7:0] brightness;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dppf_core.sv =====
`default_nettype none

module dppf_core #(
  parameter int FADE_STEP    = dppf_pkg::FADE_STEP_DEF,
  parameter int SLEEP_GAP_MS = dppf_pkg::SLEEP_GAP_MS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire dppf_pkg::req_t req,
  input  wire logic           presence,
  input  wire dppf_pkg::cfg_t cfg,
  output dppf_pkg::res_t      res_nxt
);

  localparam int SUM_W = $clog2(256 + FADE_STEP);
  localparam logic [SUM_W-1:0] STEP_W = SUM_W'(FADE_STEP);
  localparam logic [dppf_pkg::SPULSE_W-1:0] GAP = dppf_pkg::SPULSE_W'(SLEEP_GAP_MS);

  typedef struct packed {
    logic [7:0] goal;
    logic       busy;
    logic       slow;
  } fade_t;

  function automatic fade_t start_fade(input logic [7:0] now, input logic [7:0] goal);
    fade_t f;
    f.goal = goal;
    f.busy = (now != goal);
    f.slow = (goal < now);
    return f;
  endfunction

  dppf_pkg::mode_t                mode_r, mode_nxt;
  logic [dppf_pkg::IDLE_W-1:0]    idle_r, idle_nxt, idle_inc;
  logic [7:0]                     now_r, now_nxt, goal_r, goal_nxt;
  logic                           busy_r, busy_nxt, slow_r, slow_nxt;
  logic [dppf_pkg::FSTEP_W-1:0]   sfs_r, sfs_nxt, sfs_inc;
  logic [dppf_pkg::SPULSE_W-1:0]  ssp_r, ssp_nxt, ssp_inc;
  logic                           sen_r, sen_nxt;

  logic                           step_due;
  logic [7:0]                     step_level, lvl_base;
  logic [SUM_W-1:0]               cur_w, goal_w, up_w;
  logic                           written, pulse;
  fade_t                          fd;

  assign idle_inc = (&idle_r) ? idle_r : idle_r + 1'b1;
  assign sfs_inc  = (&sfs_r) ? sfs_r : sfs_r + 1'b1;
  assign ssp_inc  = (&ssp_r) ? ssp_r : ssp_r + 1'b1;

  // one fade step, clamped at the goal
  assign cur_w  = SUM_W'(now_r);
  assign goal_w = SUM_W'(goal_r);
  assign up_w   = cur_w + STEP_W;
  assign step_due = busy_r &&
                    (sfs_inc >= (slow_r ? dppf_pkg::FADE_SLOW_MS : dppf_pkg::FADE_FAST_MS));

  always_comb begin
    if (now_r < goal_r) begin
      step_level = (up_w > goal_w) ? goal_r : up_w[7:0];
    end else begin
      step_level = (cur_w >= goal_w + STEP_W) ? 8'(cur_w - STEP_W) : goal_r;
    end
  end

  // a new fade starts from the level left after this tick's step
  assign lvl_base = (req == dppf_pkg::REQ_TICK && step_due) ? step_level : now_r;

  always_comb begin
    mode_nxt = mode_r;
    idle_nxt = idle_r;
    now_nxt  = now_r;
    goal_nxt = goal_r;
    busy_nxt = busy_r;
    slow_nxt = slow_r;
    sfs_nxt  = sfs_r;
    ssp_nxt  = ssp_r;
    sen_nxt  = sen_r;
    written  = 1'b0;
    pulse    = 1'b0;
    fd       = start_fade(lvl_base, goal_r);

    case (req)
      dppf_pkg::REQ_TICK: begin
        idle_nxt = idle_inc;
        sfs_nxt  = sfs_inc;
        ssp_nxt  = ssp_inc;
        if (step_due) begin
          sfs_nxt  = '0;
          now_nxt  = step_level;
          busy_nxt = (step_level != goal_r);
          written  = 1'b1;
        end
        if (presence) begin
          idle_nxt = '0;
          if (mode_r != dppf_pkg::MODE_ACTIVE) begin
            fd       = start_fade(lvl_base, cfg.active_level);
            goal_nxt = fd.goal;
            busy_nxt = fd.busy;
            slow_nxt = fd.slow;
            sfs_nxt  = '0;
            mode_nxt = dppf_pkg::MODE_ACTIVE;
          end
        end else begin
          case (mode_r)
            dppf_pkg::MODE_ACTIVE: begin
              if (idle_inc > {1'b0, cfg.dim_timeout_ms}) begin
                fd       = start_fade(lvl_base, cfg.dimmed_level);
                goal_nxt = fd.goal;
                busy_nxt = fd.busy;
                slow_nxt = fd.slow;
                sfs_nxt  = '0;
                mode_nxt = dppf_pkg::MODE_DIMMED;
              end
            end
            dppf_pkg::MODE_DIMMED: begin
              if (sen_r && idle_inc > {1'b0, cfg.off_timeout_ms}) begin
                fd       = start_fade(lvl_base, cfg.off_level);
                goal_nxt = fd.goal;
                busy_nxt = fd.busy;
                slow_nxt = fd.slow;
                sfs_nxt  = '0;
                mode_nxt = dppf_pkg::MODE_SLEEP;
              end
            end
            dppf_pkg::MODE_SLEEP: begin
              if (!busy_nxt && ssp_inc > GAP) begin
                ssp_nxt = '0;
                pulse   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dppf_pkg::REQ_WAKE: begin
        idle_nxt = '0;
        if (mode_r != dppf_pkg::MODE_ACTIVE) begin
          fd       = start_fade(now_r, cfg.active_level);
          goal_nxt = fd.goal;
          busy_nxt = fd.busy;
          slow_nxt = fd.slow;
          sfs_nxt  = '0;
          mode_nxt = dppf_pkg::MODE_ACTIVE;
        end
      end
      dppf_pkg::REQ_DIM: begin
        fd       = start_fade(now_r, cfg.dimmed_level);
        goal_nxt = fd.goal;
        busy_nxt = fd.busy;
        slow_nxt = fd.slow;
        sfs_nxt  = '0;
        mode_nxt = dppf_pkg::MODE_DIMMED;
        idle_nxt = {1'b0, cfg.dim_timeout_ms} + dppf_pkg::MANUAL_DIM_EXTRA;
      end
      dppf_pkg::REQ_OFF: begin
        fd       = start_fade(now_r, cfg.off_level);
        goal_nxt = fd.goal;
        busy_nxt = fd.busy;
        slow_nxt = fd.slow;
        sfs_nxt  = '0;
        mode_nxt = dppf_pkg::MODE_OFF;
      end
      dppf_pkg::REQ_SLEEP_EN: begin
        sen_nxt = 1'b1;
      end
      dppf_pkg::REQ_SLEEP_DIS: begin
        sen_nxt = 1'b0;
        if (mode_r == dppf_pkg::MODE_SLEEP) begin
          mode_nxt = dppf_pkg::MODE_OFF;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.brightness         = now_nxt;
    res_nxt.brightness_written = written;
    res_nxt.mode               = mode_nxt;
    res_nxt.fading             = busy_nxt;
    res_nxt.sleep_pulse        = pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dppf_pkg::MODE_ACTIVE;
      idle_r <= '0;
      now_r  <= dppf_pkg::ACTIVE_LEVEL_RST;
      goal_r <= dppf_pkg::ACTIVE_LEVEL_RST;
      busy_r <= 1'b0;
      slow_r <= 1'b0;
      sfs_r  <= '0;
      ssp_r  <= '0;
      sen_r  <= 1'b1;
    end else if (en) begin
      mode_r <= mode_nxt;
      idle_r <= idle_nxt;
      now_r  <= now_nxt;
      goal_r <= goal_nxt;
      busy_r <= busy_nxt;
      slow_r <= slow_nxt;
      sfs_r  <= sfs_nxt;
      ssp_r  <= ssp_nxt;
      sen_r  <= sen_nxt;
    end
  end

  // not fading means the level sits on its goal
  a_idle_on_goal: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (now_r == goal_r))
    else $error("fade idle but level differs from goal");

  // a reported step really moves the level
  a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (en && written) |=> (now_r != $past(now_r)))
    else $error("fade step left level unchanged");

  a_sleep_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == dppf_pkg::MODE_SLEEP) |-> sen_r)
    else $error("sleeping while sleep disabled");

endmodule

`default_nettype wire

// ===== hw/rtl/display_presence_power_fsm_top.sv =====
// Presence-driven backlight controller.
// Input stream: one transfer per item, either a 1 ms tick with a presence
// flag or a command (wake, manual dim, manual off, sleep enable/disable).
// Output stream: one result transfer per input item carrying brightness,
// a fade-step flag, the mode, the fading flag and a sleep request pulse.
// Items pass an input register and then a result register before
// out_tvalid rises. One item per cycle is sustained while the receiver
// keeps out_tready high, since the whole state update is a single pass
// of compares and small adds.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; after that in_tready drops until the
// result is taken.
// Configuration: cfg_we writes register cfg_idx (0 active_level, 1
// dimmed_level, 2 off_level, 3 dim_timeout_ms, 4 off_timeout_ms) from
// cfg_wdata; write only while no item is in flight.
// Reset (rst_n low, synchronous) restores the register defaults, mode
// active at full brightness with sleep enabled, and empties both stages.
`default_nettype none

module display_presence_power_fsm_top #(
  parameter int FADE_STEP    = dppf_pkg::FADE_STEP_DEF,
  parameter int SLEEP_GAP_MS = dppf_pkg::SLEEP_GAP_MS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [2:0] req_type, [3] presence, [7:4] zero
  input  wire logic [dppf_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] brightness, [8] brightness_written, [10:9] mode, [11] fading,
  // [12] sleep_pulse, [15:13] zero
  output logic [dppf_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [dppf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [dppf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dppf_pkg::cfg_t  cfg_r;
  logic            in_v_r;
  dppf_pkg::req_t  in_req_r;
  logic            in_pres_r;
  logic            out_v_r;
  dppf_pkg::res_t  out_res_r;
  dppf_pkg::res_t  res_nxt;
  logic            adv, en;

  assign adv       = !out_v_r || out_tready;
  assign en        = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level   <= dppf_pkg::ACTIVE_LEVEL_RST;
      cfg_r.dimmed_level   <= dppf_pkg::DIMMED_LEVEL_RST;
      cfg_r.off_level      <= dppf_pkg::OFF_LEVEL_RST;
      cfg_r.dim_timeout_ms <= dppf_pkg::DIM_TIMEOUT_RST;
      cfg_r.off_timeout_ms <= dppf_pkg::OFF_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dppf_pkg::CFG_ACTIVE_LEVEL: cfg_r.active_level   <= cfg_wdata[7:0];
        dppf_pkg::CFG_DIMMED_LEVEL: cfg_r.dimmed_level   <= cfg_wdata[7:0];
        dppf_pkg::CFG_OFF_LEVEL:    cfg_r.off_level      <= cfg_wdata[7:0];
        dppf_pkg::CFG_DIM_TIMEOUT:  cfg_r.dim_timeout_ms <= cfg_wdata;
        dppf_pkg::CFG_OFF_TIMEOUT:  cfg_r.off_timeout_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r  <= dppf_pkg::req_t'(in_tdata[2:0]);
      in_pres_r <= in_tdata[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
    end
  end

  dppf_core #(
    .FADE_STEP    (FADE_STEP),
    .SLEEP_GAP_MS (SLEEP_GAP_MS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .req      (in_req_r),
    .presence (in_pres_r),
    .cfg      (cfg_r),
    .res_nxt  (res_nxt)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_res_r};

  // sleep requests only ever leave in sleeping mode
  a_pulse_in_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.sleep_pulse) |-> (out_res_r.mode == dppf_pkg::MODE_SLEEP))
    else $error("sleep pulse outside sleeping mode");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(out_res_r)))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_tready)
    else $error("input blocked with empty result stage");

endmodule

`default_nettype wire

// ===== sim/display_presence_power_fsm_top_tb.sv =====
`timescale 1ns / 1ps

module display_presence_power_fsm_top_tb;

  localparam int FADE_STEP = dppf_pkg::FADE_STEP_DEF;
  localparam int SLEEP_GAP = dppf_pkg::SLEEP_GAP_MS_DEF;

  // request codes the block ignores
  localparam logic [2:0] REQ_UNUSED6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED7 = 3'd7;

  class backlight_scoreboard;
    logic [7:0]        active_lvl = dppf_pkg::ACTIVE_LEVEL_RST;
    logic [7:0]        dimmed_lvl = dppf_pkg::DIMMED_LEVEL_RST;
    logic [7:0]        off_lvl    = dppf_pkg::OFF_LEVEL_RST;
    logic [23:0]       dim_to     = dppf_pkg::DIM_TIMEOUT_RST;
    logic [23:0]       off_to     = dppf_pkg::OFF_TIMEOUT_RST;
    dppf_pkg::mode_t   mode_q     = dppf_pkg::MODE_ACTIVE;
    logic [dppf_pkg::IDLE_W-1:0]   idle_ms     = '0;
    logic [7:0]                    lvl_now     = dppf_pkg::ACTIVE_LEVEL_RST;
    logic [7:0]                    lvl_goal    = dppf_pkg::ACTIVE_LEVEL_RST;
    bit                            busy        = 1'b0;
    bit                            slow        = 1'b0;
    logic [dppf_pkg::FSTEP_W-1:0]  since_step  = '0;
    logic [dppf_pkg::SPULSE_W-1:0] since_pulse = '0;
    bit                            sleep_en    = 1'b1;
    dppf_pkg::res_t    expected_q[$];
    int                errors     = 0;

    function void set_reg(logic [dppf_pkg::CFG_IDX_W-1:0] idx,
                          logic [dppf_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        dppf_pkg::CFG_ACTIVE_LEVEL: active_lvl = val[7:0];
        dppf_pkg::CFG_DIMMED_LEVEL: dimmed_lvl = val[7:0];
        dppf_pkg::CFG_OFF_LEVEL:    off_lvl    = val[7:0];
        dppf_pkg::CFG_DIM_TIMEOUT:  dim_to     = val;
        dppf_pkg::CFG_OFF_TIMEOUT:  off_to     = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void start_fade(logic [7:0] goal);
      lvl_goal   = goal;
      busy       = (lvl_now != lvl_goal);
      since_step = '0;
      slow       = (lvl_goal < lvl_now);
    endfunction

    function bit fade_step();
      int cur, tgt;
      if (!busy) return 1'b0;
      if (since_step < (slow ? dppf_pkg::FADE_SLOW_MS : dppf_pkg::FADE_FAST_MS))
        return 1'b0;
      since_step = '0;
      cur = lvl_now;
      tgt = lvl_goal;
      if (cur < tgt) cur = (cur + FADE_STEP > tgt) ? tgt : cur + FADE_STEP;
      else cur = (cur - FADE_STEP < tgt) ? tgt : cur - FADE_STEP;
      lvl_now = cur[7:0];
      if (lvl_now == lvl_goal) busy = 1'b0;
      return 1'b1;
    endfunction

    function void wake_up();
      idle_ms = '0;
      if (mode_q != dppf_pkg::MODE_ACTIVE) begin
        start_fade(active_lvl);
        mode_q = dppf_pkg::MODE_ACTIVE;
      end
    endfunction

    function void note_input(logic [dppf_pkg::IN_DATA_W-1:0] data);
      logic [2:0]     req;
      bit             pres;
      dppf_pkg::res_t r;
      req  = data[2:0];
      pres = data[3];
      r    = '0;
      case (req)
        dppf_pkg::REQ_TICK: begin
          if (idle_ms != '1) idle_ms++;
          if (since_step != '1) since_step++;
          if (since_pulse != '1) since_pulse++;
          r.brightness_written = fade_step();
          if (pres) begin
            wake_up();
          end else begin
            case (mode_q)
              dppf_pkg::MODE_ACTIVE: if (idle_ms > dim_to) begin
                start_fade(dimmed_lvl);
                mode_q = dppf_pkg::MODE_DIMMED;
              end
              dppf_pkg::MODE_DIMMED: if (sleep_en && idle_ms > off_to) begin
                start_fade(off_lvl);
                mode_q = dppf_pkg::MODE_SLEEP;
              end
              dppf_pkg::MODE_SLEEP: if (!busy && since_pulse > SLEEP_GAP) begin
                since_pulse   = '0;
                r.sleep_pulse = 1'b1;
              end
              default: ;
            endcase
          end
        end
        dppf_pkg::REQ_WAKE: wake_up();
        dppf_pkg::REQ_DIM: begin
          start_fade(dimmed_lvl);
          mode_q  = dppf_pkg::MODE_DIMMED;
          idle_ms = dppf_pkg::IDLE_W'(dim_to) + dppf_pkg::MANUAL_DIM_EXTRA;
        end
        dppf_pkg::REQ_OFF: begin
          start_fade(off_lvl);
          mode_q = dppf_pkg::MODE_OFF;
        end
        dppf_pkg::REQ_SLEEP_EN: sleep_en = 1'b1;
        dppf_pkg::REQ_SLEEP_DIS: begin
          sleep_en = 1'b0;
          if (mode_q == dppf_pkg::MODE_SLEEP) mode_q = dppf_pkg::MODE_OFF;
        end
        default: ;
      endcase
      r.brightness = lvl_now;
      r.mode       = mode_q;
      r.fading     = busy;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [dppf_pkg::OUT_DATA_W-1:0] data);
      dppf_pkg::res_t got, want;
      got = dppf_pkg::res_t'(data[$bits(dppf_pkg::res_t)-1:0]);
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing pending: %h", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.brightness !== want.brightness) begin
        $error("brightness: expected %0d, got %0d", want.brightness, got.brightness);
        errors++;
      end
      if (got.brightness_written !== want.brightness_written) begin
        $error("brightness_written: expected %0d, got %0d",
               want.brightness_written, got.brightness_written);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
      if (got.fading !== want.fading) begin
        $error("fading: expected %0d, got %0d", want.fading, got.fading);
        errors++;
      end
      if (got.sleep_pulse !== want.sleep_pulse) begin
        $error("sleep_pulse: expected %0d, got %0d", want.sleep_pulse, got.sleep_pulse);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [dppf_pkg::IN_DATA_W-1:0]   in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [dppf_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                             cfg_we;
  logic [dppf_pkg::CFG_IDX_W-1:0]   cfg_idx;
  logic [dppf_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  backlight_scoreboard sb = new();

  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  display_presence_power_fsm_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("display_presence_power_fsm_top_tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // receiver: long hold when asked, otherwise short random stalls
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [2:0] req, input logic pres);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, pres, req};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [dppf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dppf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_profile(input logic [7:0] act, input logic [7:0] dim,
                             input logic [7:0] off, input logic [23:0] dim_ms,
                             input logic [23:0] off_ms);
    write_cfg(dppf_pkg::CFG_ACTIVE_LEVEL, dppf_pkg::CFG_DATA_W'(act));
    write_cfg(dppf_pkg::CFG_DIMMED_LEVEL, dppf_pkg::CFG_DATA_W'(dim));
    write_cfg(dppf_pkg::CFG_OFF_LEVEL, dppf_pkg::CFG_DATA_W'(off));
    write_cfg(dppf_pkg::CFG_DIM_TIMEOUT, dim_ms);
    write_cfg(dppf_pkg::CFG_OFF_TIMEOUT, off_ms);
  endtask

  // runs of ticks broken by the odd command; presence on commands is don't-care
  task automatic random_items(input int n, input int cmd_pct, input int pres_pml);
    for (int i = 0; i < n; i++) begin
      if (stalls_on && n > 100 && i == n / 3) hold_left = 60;
      if ($urandom_range(0, 99) < cmd_pct)
        send_item(3'($urandom_range(dppf_pkg::REQ_WAKE, REQ_UNUSED7)), 1'($urandom));
      else
        send_item(dppf_pkg::REQ_TICK, $urandom_range(0, 999) < pres_pml);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: every request code, presence on and off
    send_item(dppf_pkg::REQ_TICK, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b1);
    send_item(dppf_pkg::REQ_WAKE, 1'b0);
    send_item(dppf_pkg::REQ_DIM, 1'b1);
    send_item(dppf_pkg::REQ_TICK, 1'b0);
    send_item(dppf_pkg::REQ_WAKE, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b0);
    send_item(dppf_pkg::REQ_OFF, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b1);
    send_item(dppf_pkg::REQ_OFF, 1'b0);
    send_item(dppf_pkg::REQ_SLEEP_DIS, 1'b0);
    send_item(dppf_pkg::REQ_SLEEP_EN, 1'b0);
    send_item(REQ_UNUSED6, 1'b1);
    send_item(REQ_UNUSED7, 1'b0);
    send_item(dppf_pkg::REQ_WAKE, 1'b1);
    drain();

    // short timeouts; sleep disable while sleeping drops to off
    set_profile(8'd60, 8'd38, 8'd17, 24'd12, 24'd25);
    send_item(dppf_pkg::REQ_DIM, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b0);
    send_item(dppf_pkg::REQ_SLEEP_DIS, 1'b0);
    send_item(dppf_pkg::REQ_WAKE, 1'b0);
    send_item(dppf_pkg::REQ_DIM, 1'b0);
    send_item(dppf_pkg::REQ_SLEEP_DIS, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b0);
    send_item(dppf_pkg::REQ_SLEEP_EN, 1'b0);
    send_item(dppf_pkg::REQ_TICK, 1'b0);

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    random_items(350, 8, 15);
    drain();

    set_profile(8'd0, 8'd255, 8'd255, 24'd0, 24'd0);
    random_items(250, 15, 30);
    drain();

    set_profile(8'd255, 8'd0, 8'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    random_items(250, 6, 5);
    drain();

    // long sleeping stretches so the pulse gap elapses; no idling from here on
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_profile(8'd100, 8'd70, 8'd45, 24'd4, 24'd9);
    random_items(830, 2, 2);
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("display_presence_power_fsm_top_tb OK");
    else
      $display("display_presence_power_fsm_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dppf_pkg.sv
hw/rtl/dppf_core.sv
hw/rtl/display_presence_power_fsm_top.sv
sim/display_presence_power_fsm_top_tb.sv
